// File: sv/fsnp_pkg.sv
`default_nettype none

package fsnp_pkg;

	localparam int unsigned ArgW      = 32;
	localparam int unsigned CharW     = 8;
	localparam int unsigned DecDigits = 10;
	localparam int unsigned HexDigits = ArgW / 4;
	localparam int unsigned BcdW      = 4 * DecDigits;
	localparam int unsigned CntW      = $clog2(DecDigits + 1);

	localparam logic [CharW-1:0] CharPercent = 8'h25;
	localparam logic [CharW-1:0] CharD       = 8'h64;
	localparam logic [CharW-1:0] CharX       = 8'h78;
	localparam logic [CharW-1:0] CharMinus   = 8'h2d;
	localparam logic [CharW-1:0] CharZero    = 8'h30;
	localparam logic [CharW-1:0] CharLowA    = 8'h61;
	localparam logic [CharW-1:0] CharNewline = 8'h0a;

	function automatic logic [CharW-1:0] digit_char(input logic [3:0] d);
		logic [CharW-1:0] wide;
		wide = {4'b0000, d};
		if (d < 4'd10) begin
			return CharZero + wide;
		end
		return CharLowA + wide - 8'd10;
	endfunction

endpackage

`default_nettype wire

// File: sv/fsnp_dabble.sv
`default_nettype none

module fsnp_dabble (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [fsnp_pkg::ArgW-1:0]     bin,
	output logic                               done,
	output logic [fsnp_pkg::BcdW-1:0]          bcd
);
	import fsnp_pkg::*;

	localparam int unsigned StepW = $clog2(ArgW);

	logic [ArgW-1:0]  bin_q;
	logic [BcdW-1:0]  bcd_q;
	logic [BcdW-1:0]  adj;
	logic [StepW-1:0] step_q;
	logic             busy_q;
	logic             done_q;

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < DecDigits; i++) begin
			adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
			                                          : bcd_q[4*i +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == StepW'(ArgW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= bin;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= {bin_q[ArgW-2:0], 1'b0};
			bcd_q <= {adj[BcdW-2:0], bin_q[ArgW-1]};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

`default_nettype wire

// File: sv/format_string_number_printer.sv
// format string printer: one format character per input word, results are
// ascii characters, one per output word, run_end on the last one of an input.
// input channel in_valid/in_ready carries fmt_char, last_char, dec_value and
// hex_value; output channel out_valid/out_ready carries out_char and run_end.
// in_ready is high only while no input is being worked on, so one input is
// processed at a time; the output register lets the next input be taken while
// the final character still waits.
// a plain character or newline is loaded into the output register from the echo
// or newline state; a bare % that is not last leaves the block waiting for input.
// a %x walks the eight hex digits one per cycle while the output can take them,
// leading zeros skipped without output, then a trailing newline if last.
// a %d runs a bit-serial binary to bcd converter on the magnitude, then emits an
// optional sign and walks ten decimal digits, one per cycle while the output can
// take them, then a trailing newline if last.
// with a full output register and out_ready low, the block holds at its next character to emit.
// reset clears the pending directive, empties the output register and returns
// to waiting for input.
`default_nettype none

module format_string_number_printer (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [fsnp_pkg::CharW-1:0]    fmt_char,
	input  wire logic                          last_char,
	input  wire logic signed [fsnp_pkg::ArgW-1:0] dec_value,
	input  wire logic [fsnp_pkg::ArgW-1:0]     hex_value,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [fsnp_pkg::CharW-1:0]         out_char,
	output logic                               run_end
);
	import fsnp_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ECHO,
		S_CONV,
		S_SIGN,
		S_DIGIT,
		S_NL
	} state_t;

	state_t           state_q;
	logic             pending_q;
	logic             last_q;
	logic             neg_q;
	logic [CharW-1:0] char_q;
	logic [BcdW-1:0]  dig_q;
	logic [CntW-1:0]  cnt_q;
	logic             lead_q;
	logic             out_valid_q;
	logic [CharW-1:0] out_char_q;
	logic             run_end_q;

	logic             accept;
	logic             can_load;
	logic             conv_start;
	logic [ArgW-1:0]  dec_bits;
	logic [ArgW-1:0]  mag;
	logic             conv_done;
	logic [BcdW-1:0]  conv_bcd;
	logic [3:0]       top_dig;
	logic             last_dig;
	logic             skip_zero;
	logic             load_out;

	assign in_ready   = (state_q == S_IDLE);
	assign accept     = in_valid && in_ready;
	assign can_load   = !out_valid_q || out_ready;
	assign conv_start = accept && pending_q && (fmt_char == CharD);
	assign dec_bits   = $unsigned(dec_value);
	assign mag        = dec_bits[ArgW-1] ? (ArgW'(0) - dec_bits) : dec_bits;
	assign top_dig    = dig_q[BcdW-1 -: 4];
	assign last_dig   = (cnt_q == CntW'(1));
	assign skip_zero  = lead_q && (top_dig == 4'd0) && !last_dig;
	assign load_out   = can_load && ((state_q == S_ECHO) || (state_q == S_SIGN) ||
		(state_q == S_NL) || ((state_q == S_DIGIT) && !skip_zero));

	fsnp_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (conv_start),
		.bin    (mag),
		.done   (conv_done),
		.bcd    (conv_bcd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pending_q   <= 1'b0;
			out_valid_q <= 1'b0;
			last_q      <= 1'b0;
			neg_q       <= 1'b0;
			char_q      <= '0;
			dig_q       <= '0;
			cnt_q       <= '0;
			lead_q      <= 1'b0;
			out_char_q  <= '0;
			run_end_q   <= 1'b0;
		end else begin
			out_valid_q <= load_out || (out_valid_q && !out_ready);
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_q <= last_char;
						if (pending_q) begin
							pending_q <= 1'b0;
							if (fmt_char == CharD) begin
								neg_q   <= dec_bits[ArgW-1];
								state_q <= S_CONV;
							end else if (fmt_char == CharX) begin
								dig_q   <= {hex_value, (BcdW - ArgW)'(0)};
								cnt_q   <= CntW'(HexDigits);
								lead_q  <= 1'b1;
								state_q <= S_DIGIT;
							end else begin
								state_q <= last_char ? S_NL : S_IDLE;
							end
						end else if (fmt_char == CharPercent) begin
							pending_q <= !last_char;
							state_q   <= last_char ? S_NL : S_IDLE;
						end else begin
							char_q  <= fmt_char;
							state_q <= S_ECHO;
						end
					end
				end
				S_ECHO: begin
					if (can_load) begin
						out_char_q  <= char_q;
						run_end_q   <= !last_q;
						state_q     <= last_q ? S_NL : S_IDLE;
					end
				end
				S_CONV: begin
					if (conv_done) begin
						dig_q   <= conv_bcd;
						cnt_q   <= CntW'(DecDigits);
						lead_q  <= 1'b1;
						state_q <= neg_q ? S_SIGN : S_DIGIT;
					end
				end
				S_SIGN: begin
					if (can_load) begin
						out_char_q  <= CharMinus;
						run_end_q   <= 1'b0;
						state_q     <= S_DIGIT;
					end
				end
				S_DIGIT: begin
					if (skip_zero) begin
						// leading zero, dropped
						dig_q <= {dig_q[BcdW-5:0], 4'd0};
						cnt_q <= cnt_q - 1'b1;
					end else if (can_load) begin
						out_char_q  <= digit_char(top_dig);
						run_end_q   <= last_dig && !last_q;
						dig_q       <= {dig_q[BcdW-5:0], 4'd0};
						cnt_q       <= cnt_q - 1'b1;
						lead_q      <= 1'b0;
						if (last_dig) begin
							state_q <= last_q ? S_NL : S_IDLE;
						end
					end
				end
				S_NL: begin
					if (can_load) begin
						out_char_q  <= CharNewline;
						run_end_q   <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign run_end   = run_end_q;

`ifndef SYNTHESIS
	a_done_in_conv: assert property (@(posedge clk) disable iff (!arst_n)
		conv_done |-> (state_q == S_CONV))
		else $error("converter finished outside conversion");

	a_last_clears_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_char) |=> !pending_q)
		else $error("directive still pending after last character");

	a_digit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIGIT) |-> (cnt_q != CntW'(0)))
		else $error("digit walk with no digits left");

	a_start_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		conv_start |=> (state_q == S_CONV))
		else $error("conversion started without entering conversion state");
`endif

endmodule

`default_nettype wire

// File: test/tb_format_string_number_printer.sv
module tb_format_string_number_printer;
	import fsnp_pkg::*;

	typedef struct packed {
		logic [CharW-1:0] ch;
		logic             fin;
	} out_word_t;

	class char_board;
		out_word_t        expected_words[$];
		logic [CharW-1:0] staged[$];
		bit               directive_armed;
		int               mismatches;
		int               shown;

		function new();
			directive_armed = 1'b0;
			mismatches = 0;
			shown = 0;
		endfunction

		function void stage_decimal(logic [ArgW-1:0] v);
			logic [ArgW-1:0]  mag;
			logic [CharW-1:0] digits[$];
			mag = v;
			if (v[ArgW-1]) begin
				staged.push_back(CharMinus);
				mag = ~v + 32'd1;
			end
			do begin
				digits.push_front(CharZero + 8'(mag % 32'd10));
				mag = mag / 32'd10;
			end while (mag != 0);
			foreach (digits[i]) staged.push_back(digits[i]);
		endfunction

		function void stage_hex(logic [ArgW-1:0] v);
			logic [3:0]       nib;
			logic [CharW-1:0] digits[$];
			do begin
				nib = v[3:0];
				if (nib < 4'd10) begin
					digits.push_front(CharZero + {4'h0, nib});
				end else begin
					digits.push_front(CharLowA + {4'h0, nib} - 8'd10);
				end
				v = v >> 4;
			end while (v != 0);
			foreach (digits[i]) staged.push_back(digits[i]);
		endfunction

		function void take_format_char(logic [CharW-1:0] c, logic l,
			logic [ArgW-1:0] d, logic [ArgW-1:0] h);
			out_word_t w;
			staged.delete();
			if (directive_armed) begin
				directive_armed = 1'b0;
				if (c == CharD) begin
					stage_decimal(d);
				end else if (c == CharX) begin
					stage_hex(h);
				end
			end else if (c == CharPercent) begin
				directive_armed = 1'b1;
			end else begin
				staged.push_back(c);
			end
			if (l) begin
				directive_armed = 1'b0;
				staged.push_back(CharNewline);
			end
			foreach (staged[i]) begin
				w.ch = staged[i];
				w.fin = (i == staged.size() - 1);
				expected_words.push_back(w);
			end
		endfunction

		function void check_out_char(logic [CharW-1:0] c, logic e);
			out_word_t w;
			if (expected_words.size() == 0) begin
				mismatches++;
				if (shown < 10) begin
					$display("unexpected output word: char %h run_end %b", c, e);
					shown++;
				end
				return;
			end
			w = expected_words.pop_front();
			if (w.ch !== c || w.fin !== e) begin
				mismatches++;
				if (shown < 10) begin
					$display("mismatch: expected char %h run_end %b, got char %h run_end %b",
						w.ch, w.fin, c, e);
					shown++;
				end
			end
		endfunction

		function bit drained();
			return expected_words.size() == 0;
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [CharW-1:0]       fmt_char = '0;
	logic                   last_char = 1'b0;
	logic signed [ArgW-1:0] dec_value = '0;
	logic [ArgW-1:0]        hex_value = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [CharW-1:0]       out_char;
	logic                   run_end;

	char_board board = new();
	bit        quiet = 1'b0;
	bit        hold_req = 1'b0;
	int        items_sent = 0;

	format_string_number_printer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.fmt_char  (fmt_char),
		.last_char (last_char),
		.dec_value (dec_value),
		.hex_value (hex_value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_char  (out_char),
		.run_end   (run_end)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [ArgW-1:0] rand_arg();
		case ($urandom_range(0, 5))
			0: return 32'h0000_0000;
			1: return 32'h8000_0000;
			2: return 32'h7fff_ffff;
			3: return 32'hffff_ffff;
			4: return $urandom >> $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [CharW-1:0] plain_char();
		logic [CharW-1:0] c;
		c = CharW'($urandom_range(0, 255));
		if (c == CharPercent) begin
			c = CharD;
		end
		return c;
	endfunction

	task automatic send_char(input logic [CharW-1:0] c, input logic l,
		input logic [ArgW-1:0] d, input logic [ArgW-1:0] h);
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 15);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		fmt_char <= c;
		last_char <= l;
		dec_value <= d;
		hex_value <= h;
		do @(posedge clk); while (in_ready !== 1'b1);
		board.take_format_char(c, l, d, h);
		items_sent++;
	endtask

	task automatic send_directive(input logic [CharW-1:0] c, input logic l,
		input logic [ArgW-1:0] d, input logic [ArgW-1:0] h);
		send_char(CharPercent, 1'b0, rand_arg(), rand_arg());
		send_char(c, l, d, h);
	endtask

	task automatic send_random_string(input bit noisy);
		int               len;
		int               kind;
		bit               tail;
		logic [CharW-1:0] c;
		len = $urandom_range(1, 8);
		for (int i = 0; i < len; i++) begin
			tail = (i == len - 1);
			if (noisy) begin
				c = CharW'($urandom_range(0, 255));
				send_char(c, tail || ($urandom_range(0, 15) == 0), rand_arg(), rand_arg());
			end else begin
				kind = $urandom_range(0, 9);
				if (tail && kind == 9) begin
					send_char(CharPercent, 1'b1, rand_arg(), rand_arg());
				end else if (kind <= 3 || kind == 9) begin
					send_char(plain_char(), tail, rand_arg(), rand_arg());
				end else if (kind <= 5) begin
					send_directive(CharD, tail, rand_arg(), rand_arg());
				end else if (kind <= 7) begin
					send_directive(CharX, tail, rand_arg(), rand_arg());
				end else begin
					c = CharW'($urandom_range(0, 255));
					send_directive(c, tail, rand_arg(), rand_arg());
				end
			end
		end
	endtask

	// output side: check accepted words, then decide ready for the next edge
	initial begin
		int gap = 0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_ready === 1'b1) begin
				board.check_out_char(out_char, run_end);
			end
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_req = 1'b0;
			end else if (gap > 0) begin
				gap--;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				gap = $urandom_range(1, 15) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		int idle = 0;
		forever begin
			@(posedge clk);
			if ((in_valid === 1'b1 && in_ready === 1'b1) ||
				(out_valid === 1'b1 && out_ready === 1'b1)) begin
				idle = 0;
			end else begin
				idle++;
			end
			if (idle >= 3000) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		bit hold_done = 1'b0;
		bit pause_done = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_char("A", 1'b0, 32'h0, 32'h0);
		send_directive(CharD, 1'b0, 32'h0000_0000, 32'hffff_ffff);
		send_directive(CharD, 1'b0, 32'h8000_0000, 32'h0);
		send_directive(CharD, 1'b0, 32'h7fff_ffff, 32'h0);
		send_directive(CharX, 1'b0, 32'hffff_ffff, 32'h0000_0000);
		send_directive(CharX, 1'b0, 32'h0, 32'hffff_ffff);
		send_directive(CharPercent, 1'b0, 32'h1, 32'h1);
		send_char(8'h00, 1'b0, 32'h0, 32'h0);
		send_directive(8'h00, 1'b0, 32'h5, 32'h5);
		send_char(CharPercent, 1'b1, 32'h8000_0000, 32'hffff_ffff);
		send_char(8'hff, 1'b1, 32'h0, 32'h0);
		send_directive(CharD, 1'b1, 32'h8000_0000, 32'h0);
		send_directive(CharX, 1'b1, 32'h0, 32'h1000_0000);
		send_directive(CharD, 1'b1, 32'hffff_ffff, 32'h0);

		while (items_sent < 245) begin
			if (items_sent >= 210) begin
				quiet = 1'b1;
			end
			if (!hold_done && items_sent >= 90) begin
				hold_req = 1'b1;
				hold_done = 1'b1;
			end
			if (!pause_done && items_sent >= 170) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (!board.drained()) @(posedge clk);
				pause_done = 1'b1;
			end
			send_random_string($urandom_range(0, 4) == 0);
		end
		in_valid <= 1'b0;

		while (!board.drained()) @(posedge clk);
		repeat (60) @(posedge clk);
		if (board.mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// File: sim.f
sv/fsnp_pkg.sv
sv/fsnp_dabble.sv
sv/format_string_number_printer.sv
test/tb_format_string_number_printer.sv
